>>> design/motor_reply_frame_checker_top_assert.svh
// assertion macros for the motor reply frame checker
// both expect clk_i and rst_ni in the scope where they are used
`ifndef MOTOR_REPLY_FRAME_CHECKER_TOP_ASSERT_SVH
`define MOTOR_REPLY_FRAME_CHECKER_TOP_ASSERT_SVH

// generic clocked property, held off during reset
`define MRFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define MRFC_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/mrfc_pkg.sv
// ----------------------------------------------------------------------------
// mrfc_pkg
// Shared types and constants of the motor reply frame checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrfc_pkg;

  localparam int unsigned PosW = 4;

  localparam logic [PosW-1:0] FramePosHead   = 4'd0;
  localparam logic [PosW-1:0] FramePosHdrSum = 4'd4;
  localparam logic [PosW-1:0] PayloadFirst   = 4'd5;
  localparam logic [PosW-1:0] FrameLast      = 4'd12;
  localparam logic [PosW-1:0] IdlePos        = 4'd13;

  localparam int unsigned PayloadBytes = 7;
  localparam int unsigned PayloadW     = 8 * PayloadBytes;

  localparam logic [7:0] HeadByteReset = 8'd62;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusBadHead  = 2'd1,
    StatusBadHdrCs = 2'd2,
    StatusBadDatCs = 2'd3
  } status_e;

  typedef struct packed {
    status_e            status;
    logic signed [7:0]  temperature;
    logic signed [15:0] torque_or_power;
    logic signed [15:0] speed;
    logic        [15:0] encoder;
  } result_t;

endpackage

`default_nettype wire

>>> design/mrfc_byte_if.sv
// ----------------------------------------------------------------------------
// mrfc_byte_if
// Received byte channel: one frame byte and its start flag per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mrfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

>>> design/mrfc_reply_if.sv
// ----------------------------------------------------------------------------
// mrfc_reply_if
// Result channel: frame status and telemetry, one beat per checked frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mrfc_reply_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [7:0]  temperature;
  logic signed [15:0] torque_or_power;
  logic signed [15:0] speed;
  logic [15:0]        encoder;

  modport source (output valid, output status, output temperature,
                  output torque_or_power, output speed, output encoder, input ready);
  modport sink   (input valid, input status, input temperature,
                  input torque_or_power, input speed, input encoder, output ready);
endinterface

`default_nettype wire

>>> design/motor_reply_frame_checker_top.sv
// a result beat is registered when the last frame byte is taken; the two-deep
// output register lets bytes flow on while a result waits; throughput: one
// byte beat per cycle (single parse register stage) while the skid is empty
// reset: idle (no frame open), head byte 62, held telemetry all zero
// ----------------------------------------------------------------------------
// motor_reply_frame_checker_top
// Parses 13-byte motor reply frames, checks head and both sums, and reports
// status with the telemetry of the last good frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module motor_reply_frame_checker_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  mrfc_byte_if.sink       rx_i,
  mrfc_reply_if.source    tx_o
);
  import mrfc_pkg::*;

  logic [7:0]          head_q;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [7:0]          sum_q, sum_d;
  status_e             err_q, err_d;
  logic [PayloadW-1:0] staged_q, staged_d;
  logic [PayloadW-1:0] held_q, held_d;

  logic            rx_beat;
  logic [PosW-1:0] pos_eff;
  logic            push;
  result_t         res_new;

  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    pop;

  assign rx_i.ready = !skid_valid_q;
  assign rx_beat    = rx_i.valid && rx_i.ready;
  assign pos_eff    = rx_i.frame_start ? FramePosHead : pos_q;

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    err_d    = err_q;
    staged_d = staged_q;
    held_d   = held_q;
    push     = 1'b0;
    if (rx_beat) begin
      pos_d = pos_eff;
      if (pos_eff < IdlePos) begin
        pos_d = pos_eff + 4'd1;
        if (pos_eff == FramePosHead) begin
          err_d    = (rx_i.rx_byte != head_q) ? StatusBadHead : StatusOk;
          sum_d    = rx_i.rx_byte;
          staged_d = '0;
        end else if (pos_eff < FramePosHdrSum) begin
          sum_d = sum_q + rx_i.rx_byte;
        end else if (pos_eff == FramePosHdrSum) begin
          if (err_q == StatusOk && rx_i.rx_byte != sum_q) err_d = StatusBadHdrCs;
          sum_d = '0;
        end else if (pos_eff < FrameLast) begin
          sum_d = sum_q + rx_i.rx_byte;
          for (int k = 0; k < PayloadBytes; k++) begin
            if (pos_eff == PayloadFirst + PosW'(k)) staged_d[8*k +: 8] = rx_i.rx_byte;
          end
        end else begin
          if (err_q == StatusOk && rx_i.rx_byte != sum_q) err_d = StatusBadDatCs;
          if (err_d == StatusOk) held_d = staged_q;
          pos_d = IdlePos;
          push  = 1'b1;
        end
      end
    end
  end

  // telemetry fields are little-endian within the held payload
  always_comb begin
    res_new.status          = err_d;
    res_new.temperature     = held_d[7:0];
    res_new.torque_or_power = held_d[23:8];
    res_new.speed           = held_d[39:24];
    res_new.encoder         = held_d[55:40];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= HeadByteReset;
      pos_q    <= IdlePos;
      sum_q    <= '0;
      err_q    <= StatusOk;
      staged_q <= '0;
      held_q   <= '0;
    end else begin
      if (cfg_we_i) head_q <= cfg_wdata_i;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      err_q    <= err_d;
      staged_q <= staged_d;
      held_q   <= held_d;
    end
  end

  // output register with one skid entry behind it
  assign pop = out_valid_q && tx_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) skid_q <= res_new;
      end else if (push) begin
        out_q <= res_new;
      end
    end else if (push) begin
      skid_q <= res_new;
    end
  end

  assign tx_o.valid           = out_valid_q;
  assign tx_o.status          = out_q.status;
  assign tx_o.temperature     = out_q.temperature;
  assign tx_o.torque_or_power = out_q.torque_or_power;
  assign tx_o.speed           = out_q.speed;
  assign tx_o.encoder         = out_q.encoder;

endmodule

`default_nettype wire

>>> design/mrfc_checker.sv
// ----------------------------------------------------------------------------
// mrfc_checker
// Port-level checks on the frame checker, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "motor_reply_frame_checker_top_assert.svh"

module mrfc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        rx_valid_i,
  input wire logic        rx_ready_i,
  input wire logic        tx_valid_i,
  input wire logic        tx_ready_i,
  input wire logic [1:0]  tx_status_i,
  input wire logic [15:0] tx_encoder_i
);

  `MRFC_ASSERT(a_tx_valid_holds, tx_valid_i && !tx_ready_i |=> tx_valid_i, "result beat dropped")
  `MRFC_ASSERT(a_tx_data_holds, tx_valid_i && !tx_ready_i |=> $stable(tx_status_i) && $stable(tx_encoder_i), "stalled result changed")
  `MRFC_ASSERT(a_result_from_byte, $rose(tx_valid_i) |-> $past(rx_valid_i && rx_ready_i), "result without a byte beat")
  `MRFC_IMPLIES(a_stall_only_when_full, !rx_ready_i, tx_valid_i, "byte stalled with empty output")

endmodule

bind motor_reply_frame_checker_top mrfc_checker u_mrfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rx_valid_i   (rx_i.valid),
  .rx_ready_i   (rx_i.ready),
  .tx_valid_i   (tx_o.valid),
  .tx_ready_i   (tx_o.ready),
  .tx_status_i  (tx_o.status),
  .tx_encoder_i (tx_o.encoder)
);

`default_nettype wire

>>> bench/motor_reply_frame_checker_top_test.sv
// ----------------------------------------------------------------------------
// motor_reply_frame_checker_top_test
// Feeds motor reply frames (good, faulty, cut short, framed by noise) into the
// checker under several head byte settings and compares each status and
// telemetry beat against a cycle-free prediction of the frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_reply_frame_checker_top_test;
  import mrfc_pkg::*;

  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseBytes  = 340;
  localparam int unsigned NumPhases   = 6;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } rx_beat_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;

  mrfc_byte_if  rx_if ();
  mrfc_reply_if tx_if ();

  motor_reply_frame_checker_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .tx_o        (tx_if)
  );

  initial forever #4 clk_i = ~clk_i;

  // byte source and reply sink state
  logic        drv_valid = 1'b0;
  logic [7:0]  drv_byte  = 8'h00;
  logic        drv_start = 1'b0;
  logic        sink_ready = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  logic        calm_rx = 1'b0;
  logic        calm_tx = 1'b0;
  int unsigned cycle_cnt    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  assign rx_if.valid       = drv_valid;
  assign rx_if.rx_byte     = drv_byte;
  assign rx_if.frame_start = drv_start;
  assign tx_if.ready       = sink_ready;

  rx_beat_t pending_bytes [$];
  result_t  expected_replies [$];

  // parser mirror
  logic [7:0]  head_expected = HeadByteReset;
  logic [3:0]  frame_pos     = IdlePos;
  logic [7:0]  frame_sum     = 8'h00;
  status_e     frame_fault   = StatusOk;
  logic [55:0] staged_telem  = '0;
  logic [55:0] held_telem    = '0;

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic predict_reply(input logic [7:0] b, input logic start);
    result_t r;
    if (start) frame_pos = FramePosHead;
    if (frame_pos != IdlePos) begin
      if (frame_pos == FramePosHead) begin
        frame_fault  = (b != head_expected) ? StatusBadHead : StatusOk;
        frame_sum    = b;
        staged_telem = '0;
      end else if (frame_pos < FramePosHdrSum) begin
        frame_sum += b;
      end else if (frame_pos == FramePosHdrSum) begin
        if (frame_fault == StatusOk && b != frame_sum) frame_fault = StatusBadHdrCs;
        frame_sum = 8'h00;
      end else if (frame_pos < FrameLast) begin
        frame_sum += b;
        staged_telem[8*(frame_pos-PayloadFirst) +: 8] = b;
      end else begin
        if (frame_fault == StatusOk && b != frame_sum) frame_fault = StatusBadDatCs;
        if (frame_fault == StatusOk) held_telem = staged_telem;
        r.status          = frame_fault;
        r.temperature     = held_telem[7:0];
        r.torque_or_power = held_telem[23:8];
        r.speed           = held_telem[39:24];
        r.encoder         = held_telem[55:40];
        expected_replies.push_back(r);
      end
      frame_pos = (frame_pos == FrameLast) ? IdlePos : frame_pos + 4'd1;
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic add_frame(input logic [7:0] head, input logic [55:0] payload,
                           input bit bad_head, input bit bad_hdr, input bit bad_dat,
                           input int unsigned n_bytes);
    logic [7:0] fb [13];
    logic [7:0] sum;
    fb[0] = bad_head ? head ^ 8'($urandom_range(1, 255)) : head;
    sum = fb[0];
    for (int k = 1; k < 4; k++) begin
      fb[k] = 8'($urandom);
      sum += fb[k];
    end
    fb[4] = bad_hdr ? sum ^ 8'($urandom_range(1, 255)) : sum;
    sum = 8'h00;
    for (int k = 0; k < 7; k++) begin
      fb[5+k] = payload[8*k +: 8];
      sum += fb[5+k];
    end
    fb[12] = bad_dat ? sum ^ 8'($urandom_range(1, 255)) : sum;
    for (int k = 0; k < n_bytes; k++) pending_bytes.push_back('{fb[k], k == 0});
  endtask

  function automatic logic [55:0] rand_payload();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2:       return {16'h8000, 16'h8000, 16'h7FFF, 8'h80};
      default: return {24'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic add_random_frames(input logic [7:0] head);
    int unsigned r;
    while (pending_bytes.size() < PhaseBytes) begin
      r = $urandom_range(0, 99);
      if (r < 55)      add_frame(head, rand_payload(), 0, 0, 0, 13);
      else if (r < 63) add_frame(head, rand_payload(), 1, 0, 0, 13);
      else if (r < 71) add_frame(head, rand_payload(), 0, 1, 0, 13);
      else if (r < 79) add_frame(head, rand_payload(), 0, 0, 1, 13);
      else if (r < 84) add_frame(head, rand_payload(), $urandom_range(0, 1), 1, 1, 13);
      else if (r < 90) add_frame(head, rand_payload(), 0, 0, 0, $urandom_range(1, 12));
      else if (r < 95) begin
        // raw noise, an occasional start among it
        repeat ($urandom_range(1, 4))
          pending_bytes.push_back('{8'($urandom), $urandom_range(0, 3) == 0});
      end else begin
        repeat ($urandom_range(1, 3)) pending_bytes.push_back('{8'($urandom), 1'b0});
        add_frame(head, rand_payload(), 0, 0, 0, 13);
      end
    end
    // finish on a whole frame so the parser is idle before the next setting
    add_frame(head, rand_payload(), 0, 0, 0, 13);
  endtask

  // byte source
  always @(posedge clk_i) begin : byte_source
    rx_beat_t beat;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      gap_left  <= 0;
    end else if (!drv_valid || rx_if.ready) begin
      if (gap_left != 0) begin
        drv_valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (pending_bytes.size() != 0) begin
        beat = pending_bytes.pop_front();
        drv_valid <= 1'b1;
        drv_byte  <= beat.data;
        drv_start <= beat.start;
        if (!calm_rx && $urandom_range(0, 99) < 25) gap_left <= idle_len();
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // reply sink back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm_tx && $urandom_range(0, 99) < 20) begin
      sink_ready <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // stretches with no idling, chosen apart for the byte side and the reply side
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) begin
      calm_rx <= $urandom_range(0, 99) < 30;
      calm_tx <= $urandom_range(0, 99) < 30;
    end
  end

  // reply check first, then prediction of the byte beat taken at this edge
  always @(posedge clk_i) begin : reply_check
    result_t want;
    if (rst_ni) begin
      if (tx_if.valid && tx_if.ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply beat, expected none, actual status %0h",
                   $time, tx_if.status);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", want.status, tx_if.status);
          check_field("temperature", want.temperature, tx_if.temperature);
          check_field("torque_or_power", want.torque_or_power, tx_if.torque_or_power);
          check_field("speed", want.speed, tx_if.speed);
          check_field("encoder", want.encoder, tx_if.encoder);
        end
      end
      if (rx_if.valid && rx_if.ready) predict_reply(rx_if.rx_byte, rx_if.frame_start);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (rx_if.valid && rx_if.ready) ||
        (tx_if.valid && tx_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0] head;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      head = HeadByteReset;
      if (p != 0) begin
        if (p == 1) head = 8'h00;
        else if (p == 2) head = 8'hFF;
        else head = 8'($urandom);
        @(posedge clk_i);
        cfg_we_i    <= 1'b1;
        cfg_wdata_i <= head;
        @(posedge clk_i);
        cfg_we_i      <= 1'b0;
        head_expected  = head;
      end
      @(negedge clk_i);
      if (p == 0) begin
        // stray byte while idle, then telemetry extremes and fault ordering
        pending_bytes.push_back('{8'hFF, 1'b0});
        add_frame(head, {16'hFFFF, 16'h7FFF, 16'h8000, 8'h80}, 0, 0, 0, 13);
        add_frame(head, '0, 1, 1, 1, 13);
        add_frame(head, '0, 0, 1, 1, 13);
        add_frame(head, rand_payload(), 0, 0, 1, 13);
        add_frame(head, rand_payload(), 0, 0, 0, 6);
        add_frame(head, {16'h0000, 16'h8000, 16'h7FFF, 8'h7F}, 0, 0, 0, 13);
      end
      add_random_frames(head);
      do @(posedge clk_i);
      while (pending_bytes.size() != 0 || drv_valid || expected_replies.size() != 0);
      repeat (DrainCycles) @(posedge clk_i);
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
